>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a condition is followed by another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/smorph_pkg.sv
// Package for the segment morph animator: widths, constants and the digit command type.
package smorph_pkg;

   localparam int NUM_DIGITS_DEFAULT = 6;
   localparam int NUM_OUT            = 6;
   localparam int PAT_W              = 8;
   localparam int TICK_W             = 16;
   localparam int STEP_W             = 4;
   localparam int DIGIT_W            = 3;

   localparam logic [PAT_W-1:0]  DOT_MASK        = 8'h80;
   localparam logic [PAT_W-1:0]  SEG_MASK        = 8'h7f;
   localparam logic [STEP_W-1:0] STEP_WRAP       = 4'd10;
   localparam logic [STEP_W-1:0] CLEAR_STEPS     = 4'd8;
   localparam logic [STEP_W-1:0] SET_OFFSET      = 4'd3;
   localparam logic [TICK_W-1:0] TICK_MAX        = 16'hffff;
   localparam logic [TICK_W-1:0] STEP_RATE_RESET = 16'd400;

   // Register word index of step_rate.
   localparam logic [0:0] REG_STEP_RATE = 1'b0;

   // Item kinds carried on tuser.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef struct packed {
      logic             tick;
      logic             write;
      logic [PAT_W-1:0] pattern;
   } digit_cmd_type;

endpackage

>>> rtl/smorph_digit.sv
// One display digit: target, shown pattern, tick and step counters with the morph step.
`include "assert_macros.svh"

module smorph_digit (
   input  logic                        clock,
   input  logic                        reset,
   input  smorph_pkg::digit_cmd_type   cmd,
   input  logic [smorph_pkg::TICK_W-1:0] step_rate,
   output logic [smorph_pkg::PAT_W-1:0]  shown_next
);
   import smorph_pkg::*;

   logic [PAT_W-1:0]  target_ff,  target_in;
   logic [PAT_W-1:0]  shown_ff,   shown_in;
   logic [TICK_W-1:0] tick_ff,    tick_in;
   logic [STEP_W-1:0] step_ff,    step_in;

   logic [PAT_W-1:0]  shw_dot;
   logic [PAT_W-1:0]  shw_step;
   logic [TICK_W-1:0] tick_inc;
   logic [STEP_W-1:0] step_inc;
   logic [STEP_W-1:0] set_idx;
   logic              expire;
   logic              differ;

   always_comb begin
      shw_dot  = (shown_ff & SEG_MASK) | (target_ff & DOT_MASK);
      tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
      expire   = tick_inc > step_rate;
      differ   = (shw_dot & SEG_MASK) != (target_ff & SEG_MASK);
      set_idx  = step_ff - SET_OFFSET;
      step_inc = step_ff + 1'b1;

      shw_step = shw_dot;
      if (step_ff < CLEAR_STEPS) begin
         shw_step = shw_step & ~(8'b1 << step_ff[2:0]);
      end
      if (step_ff >= SET_OFFSET && !set_idx[STEP_W-1]) begin
         shw_step = shw_step | (target_ff & SEG_MASK & (8'b1 << set_idx[2:0]));
      end
   end

   always_comb begin
      target_in = target_ff;
      shown_in  = shown_ff;
      tick_in   = tick_ff;
      step_in   = step_ff;
      if (cmd.write) begin
         target_in = cmd.pattern;
      end
      if (cmd.tick) begin
         shown_in = shw_dot;
         tick_in  = tick_inc;
         if (expire) begin
            tick_in = '0;
            if (differ) begin
               shown_in = shw_step;
               step_in  = (step_inc >= STEP_WRAP) ? '0 : step_inc;
            end else begin
               step_in = '0;
            end
         end
      end
   end

   assign shown_next = shown_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         shown_ff  <= '0;
         tick_ff   <= '0;
         step_ff   <= '0;
      end else begin
         target_ff <= target_in;
         shown_ff  <= shown_in;
         tick_ff   <= tick_in;
         step_ff   <= step_in;
      end
   end

   `ASSERT_ALWAYS(a_step_range, clock, reset, step_ff < STEP_WRAP, "step counter left 0..9")
   `ASSERT_ALWAYS(a_cmd_exclusive, clock, reset, !(cmd.tick && cmd.write), "tick and write at once")
   `ASSERT_NEXT(a_write_holds, clock, reset, cmd.write, $stable(shown_ff), "write moved shown")

endmodule

>>> rtl/segment_morph_animator_top.sv
// Top level of the six-digit seven-segment morph animator with stream and APB ports.
//
// The block takes one item per clock cycle while results are taken, and returns one result item
// for each. A tick item (tuser = 0) advances every digit by one tick and, where its tick counter
// passes step_rate and shown differs from target, one morph step; a write item (tuser = 1) stores
// the target pattern of one digit and reports the shown patterns unchanged. An accepted item
// waits in an input register; as it is handed on, all digit cells update side by side in plain
// compare and mask logic and its result lands in the result register, while a new item enters.
// req_tready drops only while the result register is full and not being taken. No clearing pass
// follows reset; all state is in flip-flops. The user must write step_rate only while the block
// is idle; the block itself does not enforce it.
`include "assert_macros.svh"

module segment_morph_animator_top #(
   parameter int NUM_DIGITS = smorph_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input items
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,  // digit[2:0], pattern[10:3], zero
   input  logic                                   req_tuser,  // kind[0]
   // Result items
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [smorph_pkg::NUM_OUT*smorph_pkg::PAT_W-1:0] rsp_tdata, // shown0[7:0] .. shown5[47:40]
   // Configuration
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [2:0]                             csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import smorph_pkg::*;

   // Configuration register
   logic [TICK_W-1:0] step_rate_ff, step_rate_in;
   logic              csr_wr;
   logic              csr_hit;

   // Input stage
   logic               stage_valid_ff, stage_valid_in;
   logic               stage_kind_ff,  stage_kind_in;
   logic [DIGIT_W-1:0] stage_digit_ff, stage_digit_in;
   logic [PAT_W-1:0]   stage_pat_ff,   stage_pat_in;
   logic               stage_advance;
   logic               req_accept;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [NUM_OUT*PAT_W-1:0] rsp_data_ff,  rsp_data_in;
   logic [NUM_OUT*PAT_W-1:0] result_word;

   logic [PAT_W-1:0] shown_next [NUM_DIGITS];

   // APB: always ready, one word register at word index 0.
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == REG_STEP_RATE;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {{(32-TICK_W){1'b0}}, step_rate_ff} : '0;

   always_comb begin
      step_rate_in = step_rate_ff;
      if (csr_wr) begin
         step_rate_in = csr_pwdata[TICK_W-1:0];
      end
   end

   // Advance the stage when the result register is free or being drained this cycle.
   assign stage_advance = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !stage_valid_ff || stage_advance;
   assign req_accept    = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_kind_in  = stage_kind_ff;
      stage_digit_in = stage_digit_ff;
      stage_pat_in   = stage_pat_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
         stage_kind_in  = req_tuser;
         stage_digit_in = req_tdata[DIGIT_W-1:0];
         stage_pat_in   = req_tdata[DIGIT_W+PAT_W-1:DIGIT_W];
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
   end

   // Digit cells: commands apply only in the cycle the stage hands its item on.
   for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_digit
      digit_cmd_type cmd;
      always_comb begin
         cmd.tick    = stage_advance && (stage_kind_ff == KIND_TICK);
         cmd.write   = stage_advance && (stage_kind_ff == KIND_WRITE)
                       && (32'(stage_digit_ff) == d);
         cmd.pattern = stage_pat_ff;
      end
      smorph_digit u_digit (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .step_rate  (step_rate_ff),
         .shown_next (shown_next[d])
      );
   end

   // Pack digits 0..5; report zero for digits the build does not have.
   for (genvar o = 0; o < NUM_OUT; o++) begin : g_out
      if (o < NUM_DIGITS) begin : g_have
         assign result_word[o*PAT_W +: PAT_W] = shown_next[o];
      end else begin : g_none
         assign result_word[o*PAT_W +: PAT_W] = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (stage_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_word;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_rate_ff   <= STEP_RATE_RESET;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         step_rate_ff   <= step_rate_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_kind_ff  <= stage_kind_in;
      stage_digit_ff <= stage_digit_in;
      stage_pat_ff   <= stage_pat_in;
      rsp_data_ff    <= rsp_data_in;
   end

   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, stage_valid_ff, "accepted item lost")
   `ASSERT_NEXT(a_stall_holds_stage, clock, reset, stage_valid_ff && !stage_advance, stage_valid_ff && $stable(stage_pat_ff), "stalled item dropped")
   `ASSERT_NEXT(a_advance_fills_rsp, clock, reset, stage_advance, rsp_valid_ff, "result not registered")

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the segment morph animator: directed and random stream traffic against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import smorph_pkg::*;

   localparam int NUM_DIGITS   = NUM_DIGITS_DEFAULT;
   localparam int LIMIT_CYCLES = 200_000;
   localparam int MAX_IDLE     = 16;
   localparam int SAT_TICKS    = 40;

   typedef logic [NUM_OUT-1:0][PAT_W-1:0] shown_vec_type;

   // Clock, reset and block ports; every input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata  = '0;   // digit[2:0], pattern[10:3], zero
   logic        req_tuser  = 1'b0; // kind[0]

   wire                        rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   wire [NUM_OUT*PAT_W-1:0]    rsp_tdata;  // shown0[7:0] .. shown5[47:40]

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   segment_morph_animator_top #(.NUM_DIGITS(NUM_DIGITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Predictor state: per-digit patterns and counters plus the shared step rate.
   logic [PAT_W-1:0]  tgt_pat  [NUM_DIGITS];
   logic [PAT_W-1:0]  shw_pat  [NUM_DIGITS];
   logic [TICK_W-1:0] tick_cnt [NUM_DIGITS];
   logic [STEP_W-1:0] step_cnt [NUM_DIGITS];
   logic [TICK_W-1:0] rate_reg;

   // Shown patterns still owed by the block, oldest first.
   shown_vec_type shown_due_q[$];

   int  fail_count  = 0;
   int  cycle_count = 0;
   bit  idle_on     = 1'b0;  // sender draws gaps between items
   bit  stall_on    = 1'b0;  // receiver draws stalls between items
   int  rsp_hold_len = 0;    // one long receiver hold-off, taken by the ready process

   function automatic void log_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   function automatic void morph_clear();
      for (int d = 0; d < NUM_DIGITS; d++) begin
         tgt_pat[d]  = '0;
         shw_pat[d]  = '0;
         tick_cnt[d] = '0;
         step_cnt[d] = '0;
      end
      rate_reg = STEP_RATE_RESET;
   endfunction

   // Apply one accepted item to the predictor and queue the shown patterns it reports.
   function automatic void morph_predict(input logic kind, input logic [2:0] dg,
                                         input logic [PAT_W-1:0] pat);
      logic [PAT_W-1:0] shw;
      logic [PAT_W-1:0] tgt;
      int               n;
      shown_vec_type    res;
      if (kind == KIND_WRITE) begin
         // out-of-range digits drop the write
         if (int'(dg) < NUM_DIGITS)
            tgt_pat[dg] = pat;
      end else begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            tgt = tgt_pat[d];
            shw = (shw_pat[d] & SEG_MASK) | (tgt & DOT_MASK);
            n   = int'(step_cnt[d]);
            if (tick_cnt[d] != TICK_MAX)
               tick_cnt[d] = tick_cnt[d] + 1'b1;
            if (tick_cnt[d] > rate_reg) begin
               tick_cnt[d] = '0;
               if ((shw & SEG_MASK) != (tgt & SEG_MASK)) begin
                  if (n < int'(CLEAR_STEPS))
                     shw[n] = 1'b0;
                  if (n >= int'(SET_OFFSET))
                     shw[n - int'(SET_OFFSET)] = shw[n - int'(SET_OFFSET)]
                        | (tgt[n - int'(SET_OFFSET)] & SEG_MASK[n - int'(SET_OFFSET)]);
                  n++;
                  if (n >= int'(STEP_WRAP))
                     n = 0;
               end else begin
                  n = 0;
               end
            end
            shw_pat[d]  = shw;
            step_cnt[d] = STEP_W'(n);
         end
      end
      for (int d = 0; d < NUM_OUT; d++)
         res[d] = (d < NUM_DIGITS) ? shw_pat[d] : '0;
      shown_due_q.push_back(res);
   endfunction

   // Offer one item, after a random gap while gaps are on, and hold it until the block takes it.
   task automatic send_item(input logic kind, input logic [2:0] dg, input logic [PAT_W-1:0] pat);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, pat, dg};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      morph_predict(kind, dg, pat);
   endtask

   // Drop the request and wait until every owed result has come back.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (shown_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle; the write lands at the access edge.
   task automatic write_rate(input logic [TICK_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(REG_STEP_RATE) << 2;
      csr_pwdata  <= {16'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      rate_reg = value;
   endtask

   // Register read: sample prdata at the access edge and compare with the predictor copy.
   task automatic check_rate_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 3'(REG_STEP_RATE) << 2;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {16'b0, rate_reg})
         log_mismatch($sformatf("step_rate read expected %08h got %08h",
                                {16'b0, rate_reg}, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_rate(input logic [TICK_W-1:0] value);
      settle_idle();
      write_rate(value);
      // leave the bus idle between the write and the read
      @(posedge clock);
      check_rate_readback();
   endtask

   // Mostly ticks and valid writes; a few writes to digits that do not exist.
   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         send_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
      else if (r < 94)
         send_item(KIND_WRITE, 3'($urandom_range(0, NUM_DIGITS - 1)), 8'($urandom));
      else
         send_item(KIND_WRITE, 3'($urandom_range(NUM_DIGITS, 7)), 8'($urandom));
   endtask

   // Reset value of step_rate, and dot copy on ticks that are far below the rate.
   task automatic test_reset_value();
      check_rate_readback();
      send_item(KIND_WRITE, 3'd0, 8'h80);
      send_item(KIND_TICK,  3'd0, 8'h00);
      send_item(KIND_TICK,  3'd7, 8'hff);
      send_item(KIND_WRITE, 3'd0, 8'h00);
      send_item(KIND_TICK,  3'd0, 8'h00);
   endtask

   // Step every tick: full morph runs through step seven and the wrap, plus ignored writes.
   task automatic test_directed();
      set_rate(16'd0);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      send_item(KIND_WRITE, 3'd0, 8'hff);
      send_item(KIND_WRITE, 3'd1, 8'h80);
      send_item(KIND_WRITE, 3'd2, 8'h7f);
      send_item(KIND_WRITE, 3'd3, 8'h01);
      send_item(KIND_WRITE, 3'd4, 8'h00);
      send_item(KIND_WRITE, 3'd5, 8'haa);
      send_item(KIND_WRITE, 3'd6, 8'h55);
      send_item(KIND_WRITE, 3'd7, 8'hff);
      for (int i = 0; i < 12; i++)
         send_item(KIND_TICK, 3'd0, 8'h00);
      // retarget mid-run so shown and target differ again
      send_item(KIND_WRITE, 3'd0, 8'h00);
      send_item(KIND_WRITE, 3'd5, 8'h55);
      for (int i = 0; i < 3; i++)
         send_item(KIND_TICK, 3'd0, 8'h00);
   endtask

   // Largest rate: ticks pile up and nothing steps; a smaller rate then steps at once.
   task automatic test_counter_saturation();
      set_rate(16'hffff);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      for (int d = 0; d < NUM_DIGITS; d++)
         send_item(KIND_WRITE, 3'(d), 8'($urandom) | DOT_MASK);
      for (int i = 0; i < SAT_TICKS; i++)
         send_item(KIND_TICK, 3'd0, 8'h00);
      set_rate(16'd10);
      for (int i = 0; i < 4; i++)
         send_item(KIND_TICK, 3'd0, 8'h00);
   endtask

   // Random traffic over several rates, with gap and stall stretches redrawn as it runs.
   task automatic test_random_rates();
      logic [TICK_W-1:0] rates [6];
      rates = '{16'd0, 16'd1, 16'd3, 16'd2, TICK_W'($urandom_range(0, 6)), 16'd0};
      foreach (rates[p]) begin
         set_rate(rates[p]);
         for (int i = 0; i < 110; i++) begin
            if (i % 40 == 0) begin
               idle_on  = ($urandom_range(0, 3) != 0);
               stall_on = ($urandom_range(0, 3) != 0);
            end
            send_random_item();
         end
      end
   endtask

   // Hold the receiver off while items keep coming, so the block fills and stalls its input.
   task automatic test_input_backpressure();
      set_rate(16'd1);
      idle_on      = 1'b0;
      stall_on     = 1'b0;
      rsp_hold_len = 300;
      for (int i = 0; i < 40; i++)
         send_random_item();
      stall_on = 1'b1;
      idle_on  = 1'b1;
      for (int i = 0; i < 20; i++)
         send_random_item();
   endtask

   // Receiver: per item a random stall, or the one long hold-off when one is requested.
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end
         stall = stall_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Check each accepted result against the oldest owed one, field by field.
   always @(posedge clock) begin : check_results
      shown_vec_type due;
      shown_vec_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (shown_due_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result %012h", got));
         end else begin
            due = shown_due_q.pop_front();
            for (int d = 0; d < NUM_OUT; d++)
               if (got[d] !== due[d])
                  log_mismatch($sformatf("shown%0d expected %02h got %02h", d, due[d], got[d]));
         end
      end
   end

   // Watchdog: stop a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      morph_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_directed();
      test_counter_saturation();
      test_random_rates();
      test_input_backpressure();
      settle_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/smorph_pkg.sv
rtl/smorph_digit.sv
rtl/segment_morph_animator_top.sv
bench/tb_top.sv
